/* sv/rbm_pkg.sv */
// ----------------------------------------------------------------------------
// rbm_pkg: shared constants for the RGB box mean filter
// Field widths, register indexes, reset values and reciprocal scaling.
// ----------------------------------------------------------------------------
package rbm_pkg;

	// payload and arithmetic widths
	localparam int PIX_W = 8;
	localparam int CS_W  = 12;
	localparam int WS_W  = 16;
	localparam int ROW_W = 16;
	localparam int IN_CH = 3;
	localparam int K_W   = 4;
	localparam int LW_W  = 11;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 2'd1;

	localparam int K_RESET  = 3;
	localparam int LW_RESET = 1024;

	// parameter defaults
	localparam int MAX_WIDTH_D  = 1024;
	localparam int MAX_WINDOW_D = 15;
	localparam int CHANNELS_D   = 3;

	// largest window the register can select, one chain cell per column
	localparam int NCELL    = (1 << K_W) - 1;
	localparam int AREA_MAX = NCELL * NCELL;
	localparam int AREA_W   = $clog2(AREA_MAX + 1);

	// reciprocal ceil(2^RSH / area) gives an exact floor for WS_W-bit sums
	localparam int RSH       = WS_W + AREA_W;
	localparam int RCP_W     = RSH + 1;
	localparam int CNT_W     = $clog2(RSH);
	localparam int RCP_RESET = ((1 << RSH) + K_RESET * K_RESET - 1) / (K_RESET * K_RESET);

endpackage

/* sv/rbm_cell.sv */
// ----------------------------------------------------------------------------
// rbm_cell: one column-sum cell of the horizontal window chain
// Holds the column sums of one column and hands them to its neighbor.
// ----------------------------------------------------------------------------
module rbm_cell #(
	parameter int DW = 36
) (
	input  logic          clk,
	input  logic          shift,
	input  logic [DW-1:0] d,
	output logic [DW-1:0] q
);

	logic [DW-1:0] sum_q;

	// advance one column per processed pixel
	always_ff @(posedge clk) begin
		if (shift) begin
			sum_q <= d;
		end
	end

	assign q = sum_q;

endmodule

/* sv/rbm_recip.sv */
// ----------------------------------------------------------------------------
// rbm_recip: serial reciprocal of the window area
// Computes ceil(2^RSH / k*k) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbm_recip
	import rbm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [K_W-1:0]   k,
	output logic             busy,
	output logic [RCP_W-1:0] recip
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AREA_W-1:0] rem_q;
	logic [RSH-1:0]   quo_q;
	logic [AREA_W-1:0] area;
	logic [AREA_W:0]  trial;
	logic             fits;

	assign area  = AREA_W'(k) * AREA_W'(k);
	// numerator is all ones: shift in a one each step
	assign trial = {rem_q, 1'b1};
	assign fits  = trial >= {1'b0, area};

	// restoring division, one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? AREA_W'(trial - {1'b0, area}) : AREA_W'(trial);
			quo_q  <= {quo_q[RSH-2:0], fits};
			cnt_q  <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(RSH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy  = busy_q;
	assign recip = {1'b0, quo_q} + RCP_W'(1);

endmodule

/* sv/rgb_box_mean_filter.sv */
// A result is registered once its pixel has passed the sum, multiply and divide states.
// Pixels are taken one at a time; the stages of one pixel share the column-sum
//   and line memories, read in the accept cycle and written in the sum cycle.
// Reset clears counters and sums; the line memories are not cleared.
// After reset and after each window_size write the input stalls
//   while the serial unit forms the area reciprocal.
// ----------------------------------------------------------------------------
// rgb_box_mean_filter: streaming box mean filter over padded RGB pixels
// Column sums in memory, window sums over a chain of column cells.
// ----------------------------------------------------------------------------
module rgb_box_mean_filter
	import rbm_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_D,
	parameter int MAX_WINDOW = MAX_WINDOW_D,
	parameter int CHANNELS   = CHANNELS_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LW_W-1:0]      cfg_data,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  logic [PIX_W-1:0]     red_in,
	input  logic [PIX_W-1:0]     green_in,
	input  logic [PIX_W-1:0]     blue_in,
	input  logic                 frame_start,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [PIX_W-1:0]     red_mean,
	output logic [PIX_W-1:0]     green_mean,
	output logic [PIX_W-1:0]     blue_mean,
	output logic                 row_last
);

	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int AW_W     = $clog2(MAX_WIDTH + 1);
	localparam int SLOT_W   = $clog2(MAX_WINDOW);
	localparam int CSB_W    = CHANNELS * CS_W;
	localparam int PXB_W    = CHANNELS * PIX_W;
	localparam int PROD_W   = WS_W + RCP_W;
	localparam int MOD_IT   = NCELL / MAX_WINDOW;
	localparam int AW_RESET = (LW_RESET > MAX_WIDTH) ? MAX_WIDTH : LW_RESET;
	localparam int KM_RESET = K_RESET % MAX_WINDOW;

	typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_MUL, ST_DIV} state_t;

	state_t state_q;

	// configuration and active frame settings
	logic [K_W-1:0]    k_cfg_q;
	logic [LW_W-1:0]   lw_cfg_q;
	logic [K_W-1:0]    k_cfg_eff;
	logic [AW_W-1:0]   w_cfg_eff;
	logic [K_W-1:0]    kmod_tmp;
	logic [SLOT_W-1:0] kmod_cfg;
	logic [K_W-1:0]    act_k_q;
	logic [AW_W-1:0]   act_w_q;
	logic [SLOT_W-1:0] act_kmod_q;
	logic [RCP_W-1:0]  act_rcp_q;
	logic              rc_start;
	logic              rc_busy;
	logic [RCP_W-1:0]  rc_recip;

	// counters
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;

	// accept-cycle values
	logic              pix_acc;
	logic [K_W-1:0]    k_e;
	logic [AW_W-1:0]   w_e;
	logic [SLOT_W-1:0] kmod_e;
	logic [COL_W-1:0]  col_e;
	logic [ROW_W-1:0]  row_e;
	logic [SLOT_W-1:0] slot_e;
	logic [SLOT_W-1:0] old_slot_e;
	logic              end_row;
	logic [PIX_W-1:0]  in_px [IN_CH];
	logic [PXB_W-1:0]  px_e;

	// stage 1
	logic [PXB_W-1:0]  px_s1;
	logic [PXB_W-1:0]  old_px_s1;
	logic [CSB_W-1:0]  cs_rd_s1;
	logic [COL_W-1:0]  col_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              row_zero_s1;
	logic              sub_px_s1;
	logic              col_zero_s1;
	logic              col_ge_k_s1;
	logic              emit_s1;
	logic              last_s1;

	// sums and later stages
	logic [CSB_W-1:0]  cs_new;
	logic [CSB_W-1:0]  tap;
	logic [WS_W-1:0]   ws_q   [CHANNELS];
	logic [WS_W-1:0]   ws_new [CHANNELS];
	logic              emit_s2;
	logic              last_s2;
	logic [PROD_W-1:0] prod_s3 [CHANNELS];
	logic [PIX_W-1:0]  mean_q  [IN_CH];
	logic              res_valid_q;
	logic              row_last_q;

	// memories
	logic [CSB_W-1:0]  cs_mem [MAX_WIDTH];
	logic [PXB_W-1:0]  px_mem [MAX_WINDOW][MAX_WIDTH];

	// chain
	logic [CSB_W-1:0]  cell_d [NCELL];
	logic [CSB_W-1:0]  cell_q [NCELL];
	logic              chain_shift;

	assign cfg_ready = 1'b1;
	assign rc_start  = cfg_valid && cfg_ready && (cfg_index == REG_WINDOW_SIZE);

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_cfg_q  <= K_W'(K_RESET);
			lw_cfg_q <= LW_W'(LW_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_SIZE: k_cfg_q  <= cfg_data[K_W-1:0];
				REG_LINE_WIDTH:  lw_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp register values into their working range
	always_comb begin
		k_cfg_eff = (k_cfg_q == '0) ? K_W'(1) : k_cfg_q;
		if (lw_cfg_q == '0) begin
			w_cfg_eff = AW_W'(1);
		end else if (32'(lw_cfg_q) > 32'(MAX_WIDTH)) begin
			w_cfg_eff = AW_W'(MAX_WIDTH);
		end else begin
			w_cfg_eff = AW_W'(lw_cfg_q);
		end
		kmod_tmp = k_cfg_eff;
		for (int i = 0; i < MOD_IT; i++) begin
			if (32'(kmod_tmp) >= 32'(MAX_WINDOW)) begin
				kmod_tmp = kmod_tmp - K_W'(MAX_WINDOW);
			end
		end
		if (32'(kmod_tmp) >= 32'(MAX_WINDOW)) begin
			kmod_cfg = '0;
		end else begin
			kmod_cfg = SLOT_W'(kmod_tmp);
		end
	end

	rbm_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rc_start),
		.k      (k_cfg_eff),
		.busy   (rc_busy),
		.recip  (rc_recip)
	);

	assign pix_stall = (state_q != ST_IDLE) || rc_busy || (res_valid_q && res_stall);
	assign pix_acc   = pix_valid && !pix_stall;

	assign in_px[0] = red_in;
	assign in_px[1] = green_in;
	assign in_px[2] = blue_in;

	// select frame-start values for this transaction
	always_comb begin
		k_e    = frame_start ? k_cfg_eff : act_k_q;
		w_e    = frame_start ? w_cfg_eff : act_w_q;
		kmod_e = frame_start ? kmod_cfg : act_kmod_q;
		col_e  = frame_start ? '0 : col_q;
		row_e  = frame_start ? '0 : row_q;
		slot_e = frame_start ? '0 : slot_q;
		if (slot_e >= kmod_e) begin
			old_slot_e = slot_e - kmod_e;
		end else begin
			old_slot_e = SLOT_W'(32'(slot_e) + MAX_WINDOW - 32'(kmod_e));
		end
		end_row = (32'(col_e) + 1) >= 32'(w_e);
		for (int c = 0; c < CHANNELS; c++) begin
			px_e[c*PIX_W +: PIX_W] = (c < IN_CH) ? in_px[c % IN_CH] : '0;
		end
	end

	// compute new column and window sums
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			logic [CS_W-1:0] px;
			logic [CS_W-1:0] cs;
			px = CS_W'(px_s1[c*PIX_W +: PIX_W]);
			if (row_zero_s1) begin
				cs = px;
			end else begin
				cs = cs_rd_s1[c*CS_W +: CS_W] + px;
				if (sub_px_s1) begin
					cs = cs - CS_W'(old_px_s1[c*PIX_W +: PIX_W]);
				end
			end
			cs_new[c*CS_W +: CS_W] = cs;
			if (col_zero_s1) begin
				ws_new[c] = WS_W'(cs);
			end else if (col_ge_k_s1) begin
				ws_new[c] = ws_q[c] + WS_W'(cs) - WS_W'(tap[c*CS_W +: CS_W]);
			end else begin
				ws_new[c] = ws_q[c] + WS_W'(cs);
			end
		end
	end

	// chain of column-sum cells, newest in cell 0
	assign chain_shift = (state_q == ST_SUM);
	assign tap         = cell_q[act_k_q - K_W'(1)];

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_d[i] = cs_new;
		end else begin : g_link
			assign cell_d[i] = cell_q[i-1];
		end
		rbm_cell #(
			.DW (CSB_W)
		) u_cell (
			.clk   (clk),
			.shift (chain_shift),
			.d     (cell_d[i]),
			.q     (cell_q[i])
		);
	end

	// read both memories in the accept cycle
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			cs_rd_s1  <= cs_mem[col_e];
			old_px_s1 <= px_mem[old_slot_e][col_e];
		end
	end

	// write back in the sum cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			cs_mem[col_s1]          <= cs_new;
			px_mem[slot_s1][col_s1] <= px_s1;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			px_s1       <= px_e;
			col_s1      <= col_e;
			slot_s1     <= slot_e;
			row_zero_s1 <= (row_e == '0);
			sub_px_s1   <= 32'(row_e) >= 32'(k_e);
			col_zero_s1 <= (col_e == '0);
			col_ge_k_s1 <= 32'(col_e) >= 32'(k_e);
			emit_s1     <= ((32'(row_e) + 1) >= 32'(k_e)) && ((32'(col_e) + 1) >= 32'(k_e));
			last_s1     <= (32'(col_e) + 1) == 32'(w_e);
		end
	end

	// multiply by the area reciprocal
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			for (int c = 0; c < CHANNELS; c++) begin
				prod_s3[c] <= PROD_W'(ws_q[c]) * PROD_W'(act_rcp_q);
			end
		end
	end

	// sequencer, counters, active settings and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_k_q     <= K_W'(K_RESET);
			act_w_q     <= AW_W'(AW_RESET);
			act_kmod_q  <= SLOT_W'(KM_RESET);
			act_rcp_q   <= RCP_W'(RCP_RESET);
			col_q       <= '0;
			row_q       <= '0;
			slot_q      <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				ws_q[c] <= '0;
			end
			emit_s2     <= 1'b0;
			last_s2     <= 1'b0;
			res_valid_q <= 1'b0;
			row_last_q  <= 1'b0;
			for (int c = 0; c < IN_CH; c++) begin
				mean_q[c] <= '0;
			end
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pix_acc) begin
						state_q <= ST_SUM;
						if (frame_start) begin
							act_k_q    <= k_cfg_eff;
							act_w_q    <= w_cfg_eff;
							act_kmod_q <= kmod_cfg;
							act_rcp_q  <= rc_recip;
						end
						if (end_row) begin
							col_q  <= '0;
							row_q  <= (row_e == '1) ? row_e : row_e + 1'b1;
							slot_q <= (32'(slot_e) == MAX_WINDOW - 1) ? '0 : slot_e + 1'b1;
						end else begin
							col_q  <= col_e + 1'b1;
							row_q  <= row_e;
							slot_q <= slot_e;
						end
					end
				end
				ST_SUM: begin
					state_q <= ST_MUL;
					for (int c = 0; c < CHANNELS; c++) begin
						ws_q[c] <= ws_new[c];
					end
					emit_s2 <= emit_s1;
					last_s2 <= last_s1;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_IDLE;
					if (emit_s2) begin
						res_valid_q <= 1'b1;
						row_last_q  <= last_s2;
						for (int c = 0; c < IN_CH; c++) begin
							if (c < CHANNELS) begin
								if (prod_s3[c % CHANNELS][PROD_W-1:RSH] > (PROD_W-RSH)'(255)) begin
									mean_q[c] <= '1;
								end else begin
									mean_q[c] <= PIX_W'(prod_s3[c % CHANNELS][PROD_W-1:RSH]);
								end
							end else begin
								mean_q[c] <= '0;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign red_mean   = mean_q[0];
	assign green_mean = mean_q[1];
	assign blue_mean  = mean_q[2];
	assign row_last   = row_last_q;

`ifndef SYNTH
	a_no_accept_while_recip: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc |-> !rc_busy) else $error("pixel taken while reciprocal busy");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc |=> pix_stall) else $error("second pixel taken during processing");

	a_result_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DIV)) else $error("result outside divide step");

	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(act_w_q)) else $error("column counter beyond line width");
`endif

endmodule
